[rtl/rgb_3x3_kernel_filter_top_assert.svh]
// assertion macros for the rgb 3x3 kernel filter top level
// expects clk_i and rst_ni in the scope that includes it
`ifndef RGB_3X3_KERNEL_FILTER_TOP_ASSERT_SVH
`define RGB_3X3_KERNEL_FILTER_TOP_ASSERT_SVH

// condition holds at every edge out of reset
`define RKF_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// consequent holds in the same cycle as the antecedent
`define RKF_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define RKF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rkf_pkg.sv]
// shared types, constants and kernel arithmetic of the rgb 3x3 kernel filter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rkf_pkg;

  localparam int CHAN_W         = 8;
  localparam int PIX_W          = 3 * CHAN_W;
  localparam int POS_W          = 10;
  localparam int CFG_DIM_W      = 11;
  localparam int CFG_SEL_W      = 10;
  localparam int APB_ADDR_W     = 5;
  localparam int APB_DATA_W     = 32;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int RES_PER_ITEM   = 4;
  localparam int RES_IDX_W      = 2;
  localparam int FIFO_DEPTH     = 8;
  localparam int FIFO_PTR_W     = 3;
  localparam int OCC_W          = 4;
  localparam int SUM_W          = 13;
  localparam int MAG_W          = SUM_W - 1;

  // round-to-nearest for box blur: (s + 4) / 9 via reciprocal 3641 / 2^15
  localparam logic [MAG_W-1:0] BOX_BIAS    = 12'd4;
  localparam logic [MAG_W-1:0] BOX_RECIP   = 12'd3641;
  localparam int               BOX_SHIFT   = 15;
  localparam logic [MAG_W-1:0] GAUSS_BIAS  = 12'd8;
  localparam int               GAUSS_SHIFT = 4;
  localparam logic signed [SUM_W-1:0] CHAN_MAX_S = 13'sd255;

  // register reset values
  localparam logic [CFG_DIM_W-1:0] RST_IMAGE_WIDTH  = 11'd1024;
  localparam logic [CFG_DIM_W-1:0] RST_IMAGE_HEIGHT = 11'd1024;
  localparam logic [CFG_SEL_W-1:0] RST_SEL_TOP      = 10'd0;
  localparam logic [CFG_SEL_W-1:0] RST_SEL_LEFT     = 10'd0;
  localparam logic [CFG_DIM_W-1:0] RST_SEL_BOTTOM   = 11'd1024;
  localparam logic [CFG_DIM_W-1:0] RST_SEL_RIGHT    = 11'd1024;

  typedef enum logic [1:0] {
    KERN_EDGE    = 2'd0,
    KERN_SHARPEN = 2'd1,
    KERN_BOX     = 2'd2,
    KERN_GAUSS   = 2'd3
  } kernel_e;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_KERNEL_MODE  = 3'd2,
    REG_SEL_TOP      = 3'd3,
    REG_SEL_LEFT     = 3'd4,
    REG_SEL_BOTTOM   = 3'd5,
    REG_SEL_RIGHT    = 3'd6
  } cfg_reg_e;

  typedef logic [8:0][CHAN_W-1:0] pix9_t;

  // per-pixel control that travels down the pipe
  typedef struct packed {
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic [RES_PER_ITEM-1:0] mask;
    logic                    filt;
  } meta_t;

  // one queued input pixel with up to four results
  typedef struct packed {
    logic [POS_W-1:0]                   row;
    logic [POS_W-1:0]                   col;
    logic [RES_PER_ITEM-1:0]            mask;
    logic [RES_PER_ITEM-1:0][PIX_W-1:0] pix;
  } item_t;

  // raw weighted sum of one channel over the 3x3 window
  function automatic logic signed [SUM_W-1:0] kernel_sum(kernel_e mode, pix9_t p);
    logic [9:0] side4;
    logic [9:0] corner4;
    logic signed [SUM_W-1:0] sc;
    logic signed [SUM_W-1:0] ss;
    logic signed [SUM_W-1:0] sk;
    logic signed [SUM_W-1:0] s;
    side4   = 10'(p[1]) + 10'(p[3]) + 10'(p[5]) + 10'(p[7]);
    corner4 = 10'(p[0]) + 10'(p[2]) + 10'(p[6]) + 10'(p[8]);
    sc = $signed(SUM_W'(p[4]));
    ss = $signed(SUM_W'(side4));
    sk = $signed(SUM_W'(corner4));
    case (mode)
      KERN_EDGE:    s = (sc <<< 3) - ss - sk;
      KERN_SHARPEN: s = (sc <<< 2) + sc - ss;
      KERN_BOX:     s = sc + ss + sk;
      KERN_GAUSS:   s = (sc <<< 2) + (ss <<< 1) + sk;
    endcase
    return s;
  endfunction

  // normalize, round half away from zero and clamp to one channel
  function automatic logic [CHAN_W-1:0] round_clamp(kernel_e mode,
                                                    logic signed [SUM_W-1:0] s);
    logic [MAG_W-1:0]     x;
    logic [2*MAG_W-1:0]   prod;
    logic [CHAN_W-1:0]    v;
    x    = '0;
    prod = '0;
    case (mode) inside
      KERN_BOX: begin
        x    = s[MAG_W-1:0] + BOX_BIAS;
        prod = (2*MAG_W)'(x) * (2*MAG_W)'(BOX_RECIP);
        v    = prod[BOX_SHIFT +: CHAN_W];
      end
      KERN_GAUSS: begin
        x = s[MAG_W-1:0] + GAUSS_BIAS;
        v = x[GAUSS_SHIFT +: CHAN_W];
      end
      KERN_EDGE, KERN_SHARPEN: begin
        if (s < 0) begin
          v = '0;
        end else if (s > CHAN_MAX_S) begin
          v = '1;
        end else begin
          v = s[CHAN_W-1:0];
        end
      end
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/rkf_pix_if.sv]
// input pixel channel of the rgb 3x3 kernel filter
// depends on rkf_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rkf_pix_if;
  logic                       valid;
  logic                       ready;
  logic [rkf_pkg::CHAN_W-1:0] in_red;
  logic [rkf_pkg::CHAN_W-1:0] in_green;
  logic [rkf_pkg::CHAN_W-1:0] in_blue;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  input ready);
  modport sink   (input valid, input in_red, input in_green, input in_blue,
                  output ready);
endinterface

`default_nettype wire

[rtl/rkf_res_if.sv]
// result channel of the rgb 3x3 kernel filter
// depends on rkf_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rkf_res_if;
  logic                       valid;
  logic                       ready;
  logic [rkf_pkg::POS_W-1:0]  out_row;
  logic [rkf_pkg::POS_W-1:0]  out_col;
  logic [rkf_pkg::CHAN_W-1:0] out_red;
  logic [rkf_pkg::CHAN_W-1:0] out_green;
  logic [rkf_pkg::CHAN_W-1:0] out_blue;
  logic                       run_last;

  modport source (output valid, output out_row, output out_col, output out_red,
                  output out_green, output out_blue, output run_last, input ready);
  modport sink   (input valid, input out_row, input out_col, input out_red,
                  input out_green, input out_blue, input run_last, output ready);
endinterface

`default_nettype wire

[rtl/rgb_3x3_kernel_filter_top.sv]
// rgb 3x3 kernel filter, top level; uses rkf_pkg, rkf_pix_if, rkf_res_if and
// the assertion macros in rgb_3x3_kernel_filter_top_assert.svh
// pix_i takes rgb pixels of the frame in raster order, one beat per pixel.
// res_o returns filtered (edge, sharpen, box or gaussian) or passed pixels,
// each with its row and column; run_last marks the last beat of one pixel.
// a pixel gives 0 to 4 result beats; rows go out one row late, the last
// row together with the one above it.
// a pixel passes registers s1, s2, s3 and the result queue. throughput: one
// pixel per cycle while pix_i.ready is high; the line-store memory is read
// at accept and written back in the cycle after, once per pixel; result
// beats leave at one per cycle while res_o.ready is high, so row ends and
// the last row, with 2 to 4 beats per pixel, are paced by the 8-entry queue.
// a stalled receiver fills the queue and pix_i.ready drops when the queue
// plus result-bearing pixels in flight reach 8; nothing is lost.
// reset clears counters, window, queue and registers, not the line stores;
// each entry in use is written by the first row of a frame. registers sit
// on an apb port, to be written only while the block is idle (not enforced).
`timescale 1ns / 1ps
`default_nettype none

module rgb_3x3_kernel_filter_top #(
  parameter int MAX_WIDTH  = rkf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rkf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  rkf_pix_if.sink                         pix_i,
  rkf_res_if.source                       res_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rkf_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [rkf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rkf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  // counter widths and a compare width that holds every size and position
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int DIM_A = (CW > RW) ? CW : RW;
  localparam int DIMW  = ((DIM_A > rkf_pkg::CFG_DIM_W) ? DIM_A : rkf_pkg::CFG_DIM_W) + 1;
  localparam int LINE_W = 2 * rkf_pkg::PIX_W;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [rkf_pkg::CFG_DIM_W-1:0] cfg_width_q, cfg_height_q;
  logic [rkf_pkg::CFG_SEL_W-1:0] cfg_top_q, cfg_left_q;
  logic [rkf_pkg::CFG_DIM_W-1:0] cfg_bottom_q, cfg_right_q;
  rkf_pkg::kernel_e              cfg_kernel_q;
  rkf_pkg::cfg_reg_e             cfg_idx;
  logic                          cfg_we;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  // byte offset 4*i selects register i, low address bits ignored
  assign cfg_idx = rkf_pkg::cfg_reg_e'(paddr[rkf_pkg::APB_ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= rkf_pkg::RST_IMAGE_WIDTH;
      cfg_height_q <= rkf_pkg::RST_IMAGE_HEIGHT;
      cfg_kernel_q <= rkf_pkg::KERN_EDGE;
      cfg_top_q    <= rkf_pkg::RST_SEL_TOP;
      cfg_left_q   <= rkf_pkg::RST_SEL_LEFT;
      cfg_bottom_q <= rkf_pkg::RST_SEL_BOTTOM;
      cfg_right_q  <= rkf_pkg::RST_SEL_RIGHT;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rkf_pkg::REG_IMAGE_WIDTH:  cfg_width_q  <= pwdata[rkf_pkg::CFG_DIM_W-1:0];
        rkf_pkg::REG_IMAGE_HEIGHT: cfg_height_q <= pwdata[rkf_pkg::CFG_DIM_W-1:0];
        rkf_pkg::REG_KERNEL_MODE:  cfg_kernel_q <= rkf_pkg::kernel_e'(pwdata[1:0]);
        rkf_pkg::REG_SEL_TOP:      cfg_top_q    <= pwdata[rkf_pkg::CFG_SEL_W-1:0];
        rkf_pkg::REG_SEL_LEFT:     cfg_left_q   <= pwdata[rkf_pkg::CFG_SEL_W-1:0];
        rkf_pkg::REG_SEL_BOTTOM:   cfg_bottom_q <= pwdata[rkf_pkg::CFG_DIM_W-1:0];
        rkf_pkg::REG_SEL_RIGHT:    cfg_right_q  <= pwdata[rkf_pkg::CFG_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      rkf_pkg::REG_IMAGE_WIDTH:  prdata = rkf_pkg::APB_DATA_W'(cfg_width_q);
      rkf_pkg::REG_IMAGE_HEIGHT: prdata = rkf_pkg::APB_DATA_W'(cfg_height_q);
      rkf_pkg::REG_KERNEL_MODE:  prdata = rkf_pkg::APB_DATA_W'(cfg_kernel_q);
      rkf_pkg::REG_SEL_TOP:      prdata = rkf_pkg::APB_DATA_W'(cfg_top_q);
      rkf_pkg::REG_SEL_LEFT:     prdata = rkf_pkg::APB_DATA_W'(cfg_left_q);
      rkf_pkg::REG_SEL_BOTTOM:   prdata = rkf_pkg::APB_DATA_W'(cfg_bottom_q);
      rkf_pkg::REG_SEL_RIGHT:    prdata = rkf_pkg::APB_DATA_W'(cfg_right_q);
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // accept stage: raster counters, result mask, filter decision
  // ---------------------------------------------------------------------
  logic [CW-1:0]   col_q;
  logic [RW-1:0]   row_q;
  logic [DIMW-1:0] w_eff, h_eff, col_x, row_x;
  logic            last_col, last_row, is_border, in_sel, in_acc, in_nz;
  logic [rkf_pkg::RES_PER_ITEM-1:0] in_mask;
  logic [rkf_pkg::OCC_W-1:0]        occ_q;

  // zero size acts as one, oversize as the maximum
  assign w_eff = (cfg_width_q == '0) ? DIMW'(1) :
                 ((DIMW'(cfg_width_q) > DIMW'(MAX_WIDTH)) ? DIMW'(MAX_WIDTH)
                                                          : DIMW'(cfg_width_q));
  assign h_eff = (cfg_height_q == '0) ? DIMW'(1) :
                 ((DIMW'(cfg_height_q) > DIMW'(MAX_HEIGHT)) ? DIMW'(MAX_HEIGHT)
                                                            : DIMW'(cfg_height_q));
  assign col_x = DIMW'(col_q);
  assign row_x = DIMW'(row_q);

  // counters past the end after a size change act as the last position
  assign last_col = (col_x + DIMW'(1)) >= w_eff;
  assign last_row = (row_x + DIMW'(1)) >= h_eff;

  // tests for the pixel one up and one left, i = r-1, j = c-1
  assign is_border = (row_x == DIMW'(1)) || (col_x == DIMW'(1)) ||
                     (row_x >= h_eff) || (col_x >= w_eff);
  assign in_sel    = (row_x > DIMW'(cfg_top_q)) && (row_x <= DIMW'(cfg_bottom_q)) &&
                     (col_x > DIMW'(cfg_left_q)) && (col_x <= DIMW'(cfg_right_q));

  // result order: (r-1,c-1), (r-1,c), (r,c-1), (r,c)
  assign in_mask[0] = (row_q != '0) && (col_q != '0);
  assign in_mask[1] = (row_q != '0) && last_col;
  assign in_mask[2] = last_row && (col_q != '0);
  assign in_mask[3] = last_row && last_col;
  assign in_nz      = |in_mask;

  // queue entries plus pixels in flight that will need one
  assign pix_i.ready = occ_q < rkf_pkg::OCC_W'(rkf_pkg::FIFO_DEPTH);
  assign in_acc      = pix_i.valid && pix_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // line store: one word per column, {row above, row above that}
  // ---------------------------------------------------------------------
  logic [LINE_W-1:0] line_mem [MAX_WIDTH];
  logic [LINE_W-1:0] rd_q, wr_data_q, line_word;
  logic [CW-1:0]     wr_idx_q;
  logic              wr_valid_q;

  logic                         s1_valid_q;
  logic [rkf_pkg::PIX_W-1:0]    s1_pix_q;
  logic [CW-1:0]                s1_idx_q;
  rkf_pkg::meta_t               s1_meta_q;
  logic                         fwd;
  logic [rkf_pkg::PIX_W-1:0]    up1, up2;

  // a write in the same cycle as the read of the same entry is forwarded
  assign fwd       = wr_valid_q && (wr_idx_q == s1_idx_q);
  assign line_word = fwd ? wr_data_q : rd_q;
  assign up1       = line_word[LINE_W-1 -: rkf_pkg::PIX_W];
  assign up2       = line_word[rkf_pkg::PIX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= line_mem[col_q];
    end
    if (s1_valid_q) begin
      line_mem[s1_idx_q] <= {s1_pix_q, up1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      wr_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
      wr_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q       <= {pix_i.in_red, pix_i.in_green, pix_i.in_blue};
      s1_idx_q       <= col_q;
      s1_meta_q.row  <= rkf_pkg::POS_W'(row_q);
      s1_meta_q.col  <= rkf_pkg::POS_W'(col_q);
      s1_meta_q.mask <= in_mask;
      s1_meta_q.filt <= !is_border && in_sel;
    end
    if (s1_valid_q) begin
      wr_idx_q  <= s1_idx_q;
      wr_data_q <= {s1_pix_q, up1};
    end
  end

  // ---------------------------------------------------------------------
  // 3x3 window, shifted left once per pixel
  // ---------------------------------------------------------------------
  logic [rkf_pkg::PIX_W-1:0] win_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int rr = 0; rr < 3; rr++) begin
        for (int cc = 0; cc < 3; cc++) begin
          win_q[rr][cc] <= '0;
        end
      end
    end else if (s1_valid_q) begin
      for (int rr = 0; rr < 3; rr++) begin
        win_q[rr][0] <= win_q[rr][1];
        win_q[rr][1] <= win_q[rr][2];
      end
      win_q[0][2] <= up2;
      win_q[1][2] <= up1;
      win_q[2][2] <= s1_pix_q;
    end
  end

  // ---------------------------------------------------------------------
  // sum stage: weighted channel sums, pass-through pixels captured
  // ---------------------------------------------------------------------
  logic                            s2_valid_q, s3_valid_q;
  rkf_pkg::meta_t                  s2_meta_q, s3_meta_q;
  rkf_pkg::pix9_t                  taps [3];
  logic signed [rkf_pkg::SUM_W-1:0] sum_d [3];
  logic signed [rkf_pkg::SUM_W-1:0] s3_sum_q [3];
  logic [rkf_pkg::PIX_W-1:0]       s3_pass_q [rkf_pkg::RES_PER_ITEM];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int rr = 0; rr < 3; rr++) begin
        for (int cc = 0; cc < 3; cc++) begin
          taps[ch][3*rr+cc] = win_q[rr][cc][rkf_pkg::CHAN_W*ch +: rkf_pkg::CHAN_W];
        end
      end
      sum_d[ch] = rkf_pkg::kernel_sum(cfg_kernel_q, taps[ch]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_meta_q <= s1_meta_q;
    end
    if (s2_valid_q) begin
      s3_meta_q <= s2_meta_q;
      for (int ch = 0; ch < 3; ch++) begin
        s3_sum_q[ch] <= sum_d[ch];
      end
      s3_pass_q[0] <= win_q[1][1];
      s3_pass_q[1] <= win_q[1][2];
      s3_pass_q[2] <= win_q[2][1];
      s3_pass_q[3] <= win_q[2][2];
    end
  end

  // ---------------------------------------------------------------------
  // normalize stage: round, clamp, build the queue entry
  // ---------------------------------------------------------------------
  logic [rkf_pkg::PIX_W-1:0] filt_pix;
  rkf_pkg::item_t            push_item;
  logic                      push;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      filt_pix[rkf_pkg::CHAN_W*ch +: rkf_pkg::CHAN_W] =
        rkf_pkg::round_clamp(cfg_kernel_q, s3_sum_q[ch]);
    end
    push_item.row    = s3_meta_q.row;
    push_item.col    = s3_meta_q.col;
    push_item.mask   = s3_meta_q.mask;
    push_item.pix[0] = s3_meta_q.filt ? filt_pix : s3_pass_q[0];
    push_item.pix[1] = s3_pass_q[1];
    push_item.pix[2] = s3_pass_q[2];
    push_item.pix[3] = s3_pass_q[3];
  end

  // pixels without results only update the window and line store
  assign push = s3_valid_q && (|s3_meta_q.mask);

  // ---------------------------------------------------------------------
  // result queue and beat sequencer
  // ---------------------------------------------------------------------
  rkf_pkg::item_t                     fifo_q [rkf_pkg::FIFO_DEPTH];
  rkf_pkg::item_t                     head;
  logic [rkf_pkg::FIFO_PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [rkf_pkg::OCC_W-1:0]          fifo_cnt_q;
  logic [rkf_pkg::RES_PER_ITEM-1:0]   sent_q, head_rem, sel_oh;
  logic [rkf_pkg::RES_IDX_W-1:0]      sel_idx;
  logic                               beat_last, out_acc, pop;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_item;
    end
  end

  assign head     = fifo_q[rd_ptr_q];
  assign head_rem = head.mask & ~sent_q;

  // first result of the head pixel not yet sent
  always_comb begin
    if (head_rem[0]) begin
      sel_idx = rkf_pkg::RES_IDX_W'(0);
    end else if (head_rem[1]) begin
      sel_idx = rkf_pkg::RES_IDX_W'(1);
    end else if (head_rem[2]) begin
      sel_idx = rkf_pkg::RES_IDX_W'(2);
    end else begin
      sel_idx = rkf_pkg::RES_IDX_W'(3);
    end
  end

  assign sel_oh    = rkf_pkg::RES_PER_ITEM'(1) << sel_idx;
  assign beat_last = (head_rem & ~sel_oh) == '0;

  // results 0 and 1 lie one row up, results 0 and 2 one column left
  assign res_o.valid     = fifo_cnt_q != '0;
  assign res_o.out_row   = sel_idx[1] ? head.row : head.row - rkf_pkg::POS_W'(1);
  assign res_o.out_col   = sel_idx[0] ? head.col : head.col - rkf_pkg::POS_W'(1);
  assign res_o.out_red   = head.pix[sel_idx][rkf_pkg::PIX_W-1 -: rkf_pkg::CHAN_W];
  assign res_o.out_green = head.pix[sel_idx][rkf_pkg::CHAN_W +: rkf_pkg::CHAN_W];
  assign res_o.out_blue  = head.pix[sel_idx][rkf_pkg::CHAN_W-1:0];
  assign res_o.run_last  = beat_last;

  assign out_acc = res_o.valid && res_o.ready;
  assign pop     = out_acc && beat_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q      <= '0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
      sent_q     <= '0;
    end else begin
      occ_q      <= occ_q + rkf_pkg::OCC_W'(in_acc && in_nz) - rkf_pkg::OCC_W'(pop);
      fifo_cnt_q <= fifo_cnt_q + rkf_pkg::OCC_W'(push) - rkf_pkg::OCC_W'(pop);
      if (push) begin
        wr_ptr_q <= wr_ptr_q + rkf_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + rkf_pkg::FIFO_PTR_W'(1);
        sent_q   <= '0;
      end else if (out_acc) begin
        sent_q <= sent_q | sel_oh;
      end
    end
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
`include "rgb_3x3_kernel_filter_top_assert.svh"

  `RKF_ASSERT_ALWAYS(a_occ_bound, occ_q <= rkf_pkg::OCC_W'(rkf_pkg::FIFO_DEPTH), "occ over depth")
  `RKF_ASSERT_ALWAYS(a_fifo_le_occ, fifo_cnt_q <= occ_q, "queue holds more than reserved")
  `RKF_ASSERT_IMPLIES(a_head_pending, res_o.valid, head_rem != '0, "head pixel has nothing left")
  `RKF_ASSERT_NEXT(a_sent_clear, pop, sent_q == '0, "sent mask not cleared after last beat")

endmodule

`default_nettype wire
